// ----- sv/rhsm_pkg.sv -----
// shared types and constants for the rolling hash string matcher
// no dependencies; used by rhsm_cfg, rhsm_cell and the top level

package rhsm_pkg;

    // widths fixed by the item and register formats
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 2;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = 4;

    // default window depth
    localparam int MAX_PATTERN = 16;

    // register indexes (byte address / 8)
    localparam logic [REG_IDX_W-1:0] REG_PAT_LO = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HI = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEN    = 2'd2;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [LEN_W-1:0]      len;     // clamped active length
        logic                  len_wr;  // pattern length written this cycle
    } cfg_t;

endpackage

// ----- sv/rhsm_cfg.sv -----
// configuration register file with apb-style access
// depends on rhsm_pkg

module rhsm_cfg #(
    parameter int MAX_PATTERN = rhsm_pkg::MAX_PATTERN
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rhsm_pkg::ADDR_W-1:0]      paddr,
    input  logic [rhsm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rhsm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rhsm_pkg::cfg_t                   cfg
);

    logic [rhsm_pkg::CFG_DATA_W-1:0] pat_lo_reg, pat_lo_next;
    logic [rhsm_pkg::CFG_DATA_W-1:0] pat_hi_reg, pat_hi_next;
    logic [rhsm_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [rhsm_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rhsm_pkg::ADDR_W-1:rhsm_pkg::ADDR_W-rhsm_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        pat_lo_next = pat_lo_reg;
        pat_hi_next = pat_hi_reg;
        len_next    = len_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rhsm_pkg::REG_PAT_LO: pat_lo_next = pwdata;
                rhsm_pkg::REG_PAT_HI: pat_hi_next = pwdata;
                rhsm_pkg::REG_LEN:    len_next    = pwdata[rhsm_pkg::LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            len_reg    <= rhsm_pkg::LEN_W'(1);
        end
        else
        begin
            pat_lo_reg <= pat_lo_next;
            pat_hi_reg <= pat_hi_next;
            len_reg    <= len_next;
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            rhsm_pkg::REG_PAT_LO: prdata = pat_lo_reg;
            rhsm_pkg::REG_PAT_HI: prdata = pat_hi_reg;
            rhsm_pkg::REG_LEN:    prdata = rhsm_pkg::CFG_DATA_W'(len_reg);
            default:              prdata = '0;
        endcase
    end

    // active length: zero acts as one, clamp to the window depth
    always_comb
    begin
        cfg.pat_lo = pat_lo_reg;
        cfg.pat_hi = pat_hi_reg;
        if (len_reg == '0)
            cfg.len = rhsm_pkg::LEN_W'(1);
        else if (len_reg > rhsm_pkg::LEN_W'(MAX_PATTERN))
            cfg.len = rhsm_pkg::LEN_W'(MAX_PATTERN);
        else
            cfg.len = len_reg;
        cfg.len_wr = wr_en && (reg_idx == rhsm_pkg::REG_LEN);
    end

endmodule

// ----- sv/rhsm_cell.sv -----
// one window cell: holds a text byte, hands it on, compares the incoming byte
// depends on rhsm_pkg

module rhsm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic                        clear,
    input  logic                        active,
    input  logic [rhsm_pkg::BYTE_W-1:0] byte_in,
    input  logic [rhsm_pkg::BYTE_W-1:0] pat_byte,
    output logic [rhsm_pkg::BYTE_W-1:0] byte_out,
    output logic                        mismatch
);

    logic [rhsm_pkg::BYTE_W-1:0] byte_reg, byte_next;

    // byte entering this cell on the shift, checked against its pattern byte
    assign mismatch = active && (byte_in != pat_byte);
    assign byte_out = byte_reg;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
            byte_next = '0;
        else if (shift_en)
            byte_next = byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else
            byte_reg <= byte_next;
    end

endmodule

// ----- sv/rolling_hash_string_matcher.sv -----
// Streaming pattern matcher. Each text byte is one input item and gives one
// result item in the next cycle; one item is taken every clock cycle while
// the output register is empty or its last result drains, else input stalls.
// The window is a chain of MAX_PATTERN byte cells that shift on every item;
// each cell compares its incoming byte with its pattern byte, so a match is
// the window being full and no active cell disagreeing. That equality also
// fixes the base-5 window hash to the pattern hash, so no hash is kept.
// match travels on tuser, the start index of the window on tdata (zero
// without a match). Writing the pattern length empties the window; the end
// of text flag clears window and position after its byte. Positions
// saturate at all ones. The pattern is configured through the apb port.
// depends on rhsm_pkg, rhsm_cfg and rhsm_cell

module rolling_hash_string_matcher #(
    parameter int MAX_PATTERN = rhsm_pkg::MAX_PATTERN
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // text input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // text_char[7:0]
    input  logic                             s_tlast,   // end_of_text
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // match_start[31:0]
    output logic                             m_tuser,   // match
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rhsm_pkg::ADDR_W-1:0]      paddr,
    input  logic [rhsm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rhsm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    rhsm_pkg::cfg_t cfg;

    logic [rhsm_pkg::BYTE_W-1:0] pat_bytes [rhsm_pkg::PAT_BYTES];
    logic [rhsm_pkg::BYTE_W-1:0] chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]      mismatch;

    logic                        accept;
    logic                        hit;
    logic                        full_after;

    logic [rhsm_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [rhsm_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        match_reg, match_next;
    logic [rhsm_pkg::POS_W-1:0]  start_reg, start_next;

    // configuration registers
    rhsm_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pattern bytes, byte 0 lowest
    generate
        for (genvar b = 0; b < rhsm_pkg::PAT_BYTES / 2; b++)
        begin : g_pat
            assign pat_bytes[b]   = cfg.pat_lo[b*rhsm_pkg::BYTE_W +: rhsm_pkg::BYTE_W];
            assign pat_bytes[b+8] = cfg.pat_hi[b*rhsm_pkg::BYTE_W +: rhsm_pkg::BYTE_W];
        end
    endgenerate

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign chain[0] = s_tdata;

    // window cells, cell 0 holds the newest byte
    generate
        for (genvar k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [rhsm_pkg::LEN_W-1:0] sel;
            assign sel = cfg.len - rhsm_pkg::LEN_W'(1) - rhsm_pkg::LEN_W'(k);

            rhsm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .clear    (accept && s_tlast),
                .active   (rhsm_pkg::LEN_W'(k) < cfg.len),
                .byte_in  (chain[k]),
                .pat_byte (pat_bytes[sel[rhsm_pkg::PAT_IDX_W-1:0]]),
                .byte_out (chain[k+1]),
                .mismatch (mismatch[k])
            );
        end
    endgenerate

    // window full once this byte is in
    assign full_after = (fill_reg >= cfg.len - rhsm_pkg::LEN_W'(1));
    assign hit        = full_after && (mismatch == '0);

    // fill count and text position
    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (cfg.len_wr)
            fill_next = '0;
        if (accept)
        begin
            if (s_tlast)
            begin
                fill_next = '0;
                pos_next  = '0;
            end
            else
            begin
                if (fill_reg < cfg.len)
                    fill_next = fill_reg + rhsm_pkg::LEN_W'(1);
                if (pos_reg != '1)
                    pos_next = pos_reg + rhsm_pkg::POS_W'(1);
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        match_next     = match_reg;
        start_next     = start_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            match_next     = hit;
            start_next     = hit ? pos_reg - rhsm_pkg::POS_W'(cfg.len) + rhsm_pkg::POS_W'(1)
                                 : '0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        start_reg <= start_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = match_reg;
    assign m_tdata  = start_reg;

    // checks
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cfg.len)
        else $error("fill count beyond active length");

    a_no_match_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("start index set without a match");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (fill_reg == '0 && pos_reg == '0))
        else $error("end of text did not clear window state");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output register");

    a_match_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit) |-> (fill_reg + rhsm_pkg::LEN_W'(1) >= cfg.len))
        else $error("match reported on a partly filled window");

endmodule

// ----- dv/tb_rolling_hash_string_matcher.sv -----
`timescale 1ns / 100ps
// testbench for rolling_hash_string_matcher: a directed table, then random pattern setups
// with text streams, every result item checked against its table entry or a predictor of the window match
// depends on rhsm_pkg and the rolling_hash_string_matcher rtl

module tb_rolling_hash_string_matcher;

    localparam int          CLK_PERIOD   = 20;
    localparam int          RANDOM_ITEMS = 1800;
    localparam logic [31:0] HASH_BASE    = 32'd5;
    localparam logic [31:0] CHAR_OFFSET  = 32'd96;
    localparam logic [127:0] LONG_PAT    = 128'hFF00_0161_5A3C_C37E_8001_7F60_5F00_FFA5;

    typedef enum logic [1:0] {ROW_CFG, ROW_TEXT, ROW_CHECK} row_kind_t;

    typedef struct packed {
        row_kind_t                               kind;
        logic [rhsm_pkg::REG_IDX_W-1:0]          reg_idx;
        logic [rhsm_pkg::CFG_DATA_W-1:0]         value;
        logic [7:0]                              ch;
        logic                                    last;
        logic                                    hit;
        logic [31:0]                             start;
    } row_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] start;
    } match_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;   // text_char[7:0]
    logic                            s_tlast;   // end_of_text
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;   // match_start[31:0]
    logic                            m_tuser;   // match
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rhsm_pkg::ADDR_W-1:0]     paddr;
    logic [rhsm_pkg::CFG_DATA_W-1:0] pwdata;
    logic [rhsm_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // predictor copy of configuration and window
    logic [rhsm_pkg::CFG_DATA_W-1:0] pat_lo;
    logic [rhsm_pkg::CFG_DATA_W-1:0] pat_hi;
    logic [rhsm_pkg::LEN_W-1:0]      pat_len;
    logic [7:0]                      win_bytes [rhsm_pkg::MAX_PATTERN];
    logic [31:0]                     win_hash;
    int unsigned                     win_fill;
    logic [31:0]                     text_pos;

    match_t      expected_matches [$];
    int unsigned mismatch_count;
    bit          src_calm;
    bit          sink_calm;

    rolling_hash_string_matcher u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(CLK_PERIOD * 600_000);
        $display("tb_rolling_hash_string_matcher failed");
        $finish;
    end

    // length in use, clamped to 1..MAX_PATTERN
    function automatic int unsigned active_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > rhsm_pkg::MAX_PATTERN)
            return rhsm_pkg::MAX_PATTERN;
        return 32'(pat_len);
    endfunction

    function automatic logic [7:0] pat_byte(int unsigned j);
        logic [127:0] both;
        both = {pat_hi, pat_lo};
        return both[8*j +: 8];
    endfunction

    // byte minus 96, wrapping like every hash term
    function automatic logic [31:0] char_term(logic [7:0] c);
        return {24'd0, c} - CHAR_OFFSET;
    endfunction

    function automatic row_t cfg_row(logic [rhsm_pkg::REG_IDX_W-1:0] idx,
                                     logic [rhsm_pkg::CFG_DATA_W-1:0] value);
        row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic row_t text_row(logic [7:0] ch, logic last);
        row_t r;
        r      = '0;
        r.kind = ROW_TEXT;
        r.ch   = ch;
        r.last = last;
        return r;
    endfunction

    function automatic row_t check_row(logic [7:0] ch, logic last, logic hit,
                                       logic [31:0] start);
        row_t r;
        r       = '0;
        r.kind  = ROW_CHECK;
        r.ch    = ch;
        r.last  = last;
        r.hit   = hit;
        r.start = start;
        return r;
    endfunction

    // advance the window by one text byte and work out its match item
    task automatic match_text(input logic [7:0] ch, input logic last, output match_t res);
        int unsigned n;
        int          j;
        logic [31:0] top_w;
        logic [31:0] pat_h;
        logic [31:0] drop;
        n     = active_len();
        top_w = 32'd1;
        pat_h = 32'd0;
        for (j = 0; j + 1 < n; j++)
            top_w = top_w * HASH_BASE;
        for (j = 0; j < n; j++)
            pat_h = pat_h * HASH_BASE + char_term(pat_byte(j));

        // roll the oldest byte out once the window is full
        if (win_fill >= n)
        begin
            drop     = char_term(win_bytes[n-1]) * top_w;
            win_hash = (win_hash - drop) * HASH_BASE + char_term(ch);
        end
        else
        begin
            win_hash = win_hash * HASH_BASE + char_term(ch);
            win_fill++;
        end
        for (j = rhsm_pkg::MAX_PATTERN - 1; j > 0; j--)
            win_bytes[j] = win_bytes[j-1];
        win_bytes[0] = ch;

        // hash hit confirmed byte by byte, oldest byte against pattern byte 0
        res = '0;
        if (win_fill >= n && win_hash == pat_h)
        begin
            res.hit = 1'b1;
            for (j = 0; j < n; j++)
                if (win_bytes[n-1-j] != pat_byte(j))
                    res.hit = 1'b0;
            if (res.hit)
                res.start = text_pos - (n - 1);
        end

        // position saturates at all ones
        if (text_pos != 32'hFFFF_FFFF)
            text_pos++;

        // end of text clears window and position after the byte
        if (last)
        begin
            for (j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
                win_bytes[j] = 8'h00;
            win_hash = 32'd0;
            win_fill = 0;
            text_pos = 32'd0;
        end
    endtask

    // apb write: setup and access phases, then idle
    task automatic write_reg(input logic [rhsm_pkg::REG_IDX_W-1:0] idx,
                             input logic [rhsm_pkg::CFG_DATA_W-1:0] value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (rdy !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rhsm_pkg::REG_PAT_LO: pat_lo = value;
            rhsm_pkg::REG_PAT_HI: pat_hi = value;
            rhsm_pkg::REG_LEN:
            begin
                pat_len  = value[rhsm_pkg::LEN_W-1:0];
                win_hash = 32'd0;
                win_fill = 0;
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one text item with a random lead-in gap; the expectation is stored on acceptance
    task automatic send_text(input logic [7:0] ch, input logic last, input bit typed,
                             input match_t typed_res);
        int unsigned gap;
        logic        rdy;
        match_t      res;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (rdy !== 1'b1);
        match_text(ch, last, res);
        expected_matches = {expected_matches, (typed ? typed_res : res)};
    endtask

    // drain every outstanding result before touching the registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // result side: random stalls, checks against the oldest expectation
    initial
    begin : result_sink
        int unsigned gap;
        logic        got;
        logic        got_hit;
        logic [31:0] got_start;
        match_t      want;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, 13);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                got       = m_tvalid;
                got_hit   = m_tuser;
                got_start = m_tdata;
                @(posedge clk);
            end
            while (got !== 1'b1);
            if (expected_matches.size() == 0)
            begin
                $display("%0t: result item with none expected: match %b start %0d",
                         $time, got_hit, got_start);
                mismatch_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (got_hit !== want.hit)
                begin
                    $display("%0t: match expected %b actual %b", $time, want.hit, got_hit);
                    mismatch_count++;
                end
                if (got_start !== want.start)
                begin
                    $display("%0t: match_start expected %0d actual %0d",
                             $time, want.start, got_start);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        row_t                       dir_rows [$];
        match_t                     typed_res;
        int unsigned                sent;
        int unsigned                phase_len;
        int unsigned                k;
        int unsigned                n;
        int unsigned                sel;
        int                         j;
        bit                         first;
        logic [127:0]               new_pat;
        logic [7:0]                 sym0;
        logic [7:0]                 sym1;
        logic [rhsm_pkg::LEN_W-1:0] new_len;

        // predictor reset state
        pat_lo   = '0;
        pat_hi   = '0;
        pat_len  = rhsm_pkg::LEN_W'(1);
        for (j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
            win_bytes[j] = 8'h00;
        win_hash = 32'd0;
        win_fill = 0;
        text_pos = 32'd0;
        mismatch_count = 0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: one-byte pattern of 00
        dir_rows = {dir_rows, check_row(8'h00, 1'b0, 1'b1, 32'd0)};
        dir_rows = {dir_rows, check_row(8'hFF, 1'b0, 1'b0, 32'd0)};
        dir_rows = {dir_rows, check_row(8'h00, 1'b1, 1'b1, 32'd2)};
        // position back to zero after the end of text
        dir_rows = {dir_rows, check_row(8'h00, 1'b0, 1'b1, 32'd0)};
        // "abc", length 3
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_PAT_LO, 64'h0000_0000_0063_6261)};
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_LEN, 64'd3)};
        dir_rows = {dir_rows, check_row(8'h61, 1'b0, 1'b0, 32'd0)};
        dir_rows = {dir_rows, check_row(8'h62, 1'b0, 1'b0, 32'd0)};
        dir_rows = {dir_rows, check_row(8'h63, 1'b0, 1'b1, 32'd1)};
        // bytes below 'a' and the top byte give wrapped hash terms
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_PAT_LO, 64'h0000_0000_FF5F_2000)};
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_LEN, 64'd5)};
        dir_rows = {dir_rows, text_row(8'h00, 1'b0)};
        dir_rows = {dir_rows, text_row(8'h20, 1'b0)};
        dir_rows = {dir_rows, text_row(8'h5F, 1'b0)};
        dir_rows = {dir_rows, text_row(8'hFF, 1'b0)};
        dir_rows = {dir_rows, text_row(8'h00, 1'b1)};
        // length 0 acts as 1
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_LEN, 64'd0)};
        dir_rows = {dir_rows, check_row(8'h00, 1'b0, 1'b1, 32'd0)};
        dir_rows = {dir_rows, check_row(8'h7F, 1'b0, 1'b0, 32'd0)};
        // widest window: length 31 acts as MAX_PATTERN
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_PAT_LO, LONG_PAT[63:0])};
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_PAT_HI, LONG_PAT[127:64])};
        dir_rows = {dir_rows, cfg_row(rhsm_pkg::REG_LEN, 64'd31)};
        for (j = 0; j < 16; j++)
            dir_rows = {dir_rows, text_row(LONG_PAT[8*j +: 8], j == 15)};
        dir_rows = {dir_rows, text_row(LONG_PAT[7:0], 1'b0)};

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
                end
                ROW_TEXT:
                    send_text(dir_rows[i].ch, dir_rows[i].last, 1'b0, '0);
                default:
                begin
                    typed_res.hit   = dir_rows[i].hit;
                    typed_res.start = dir_rows[i].start;
                    send_text(dir_rows[i].ch, dir_rows[i].last, 1'b1, typed_res);
                end
            endcase
        end

        // random phases: optional new pattern setup, then text built mostly from pattern bytes
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            sym0 = 8'($urandom_range(0, 255));
            sym1 = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                new_pat = {$urandom, $urandom, $urandom, $urandom};
            else
                for (j = 0; j < 16; j++)
                    new_pat[8*j +: 8] = $urandom_range(0, 1) ? sym1 : sym0;

            sel = $urandom_range(0, 19);
            if (sel == 0)
                new_len = '0;
            else if (sel == 1)
                new_len = rhsm_pkg::LEN_W'(rhsm_pkg::MAX_PATTERN);
            else if (sel == 2)
                new_len = rhsm_pkg::LEN_W'($urandom_range(17, 31));
            else if (sel < 6)
                new_len = rhsm_pkg::LEN_W'($urandom_range(7, 15));
            else
                new_len = rhsm_pkg::LEN_W'($urandom_range(1, 6));

            // pattern bytes alone keep the window; a length write empties it
            if (first || $urandom_range(0, 2) != 0)
            begin
                wait_idle();
                write_reg(rhsm_pkg::REG_PAT_LO, new_pat[63:0]);
                if (first || $urandom_range(0, 1) != 0)
                    write_reg(rhsm_pkg::REG_PAT_HI, new_pat[127:64]);
                if (first || $urandom_range(0, 1) != 0)
                    write_reg(rhsm_pkg::REG_LEN,
                              {{(rhsm_pkg::CFG_DATA_W-rhsm_pkg::LEN_W){1'b0}}, new_len});
            end
            first = 1'b0;

            phase_len = $urandom_range(20, 80);
            k = 0;
            while (k < phase_len)
            begin
                n   = active_len();
                sel = $urandom_range(0, 19);
                if (sel < 3)
                begin
                    // whole pattern in a row, sometimes closing the text
                    for (j = 0; j < n; j++)
                        send_text(pat_byte(j), (j == n - 1) && ($urandom_range(0, 7) == 0),
                                  1'b0, '0);
                    k += n;
                end
                else
                begin
                    send_text((sel == 3) ? 8'($urandom) : pat_byte($urandom_range(0, n - 1)),
                              $urandom_range(0, 39) == 0, 1'b0, '0);
                    k++;
                end
            end
            sent += k;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rolling_hash_string_matcher passed");
        else
            $display("tb_rolling_hash_string_matcher failed");
        $finish;
    end

endmodule
